@@ hw/rtl/pfcd_pkg.sv @@
// Package for the panel frame CRC-8 decoder: word types, frame layout
// constants, level codes and the byte-wise CRC-8/Maxim step.
// No dependencies.
`timescale 1ns / 1ps

package pfcd_pkg;

   localparam logic       KIND_STATUS = 1'b0;
   localparam logic       KIND_BUTTON = 1'b1;

   localparam logic [7:0] CRC_POLY    = 8'h8C;
   localparam logic [7:0] STATUS_SYNC = 8'hFF;
   localparam logic [7:0] STATUS_TAG  = 8'h01;
   localparam logic [7:0] BUTTON_SYNC = 8'h00;
   localparam logic [7:0] FRAME_END   = 8'hFF;

   localparam logic [2:0] INDEX_MAX     = 3'd7;
   localparam logic [2:0] SYNC_AT       = 3'd0;
   localparam logic [2:0] STATUS_TAG_AT = 3'd1;
   localparam logic [2:0] STATUS_END_AT = 3'd4;
   localparam logic [2:0] BUTTON_END_AT = 3'd3;
   localparam logic [2:0] STATUS_WLO_AT = 3'd2;
   localparam logic [2:0] BUTTON_WLO_AT = 3'd1;
   localparam logic [2:0] STATUS_CRC_AT = 3'd5;
   localparam logic [2:0] BUTTON_CRC_AT = 3'd4;
   localparam logic [2:0] STATUS_LEN    = 3'd6;
   localparam logic [2:0] BUTTON_LEN    = 3'd5;

   localparam logic [15:0] KNOWN_MASK = 16'h01FE;
   localparam int          SUMMER_BIT = 4;
   localparam int          NOTIFY_BIT = 5;
   localparam int          AIR_MIN_BIT  = 6;
   localparam int          AIR_NORM_BIT = 7;
   localparam int          AIR_MAX_BIT  = 8;

   localparam logic [1:0] AIRFLOW_MIN     = 2'd0;
   localparam logic [1:0] AIRFLOW_NORM    = 2'd1;
   localparam logic [1:0] AIRFLOW_MAX     = 2'd2;
   localparam logic [1:0] AIRFLOW_UNKNOWN = 2'd3;

   localparam logic [2:0] TEMP_NONE     = 3'd0;
   localparam logic [2:0] TEMP_LOW      = 3'd1;
   localparam logic [2:0] TEMP_LOW_MED  = 3'd2;
   localparam logic [2:0] TEMP_MED      = 3'd3;
   localparam logic [2:0] TEMP_MED_HIGH = 3'd4;
   localparam logic [2:0] TEMP_HIGH     = 3'd5;
   localparam logic [2:0] TEMP_UNKNOWN  = 3'd6;

   typedef struct packed {
      logic       func;
      logic [7:0] frame_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic        accepted;
      logic        frame_kind;
      logic [15:0] payload_word;
      logic [1:0]  fan_level;
      logic [2:0]  heat_level;
      logic        summer_flag;
      logic        alert_flag;
      logic [15:0] spare_bits;
   } rsp_word_type;

   typedef struct packed {
      logic        accepted;
      logic        kind;
      logic [15:0] word;
   } frame_summary_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/pfcd_ifs.sv @@
// Valid/ready channel interfaces for the panel frame CRC-8 decoder.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

interface pfcd_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] frame_byte;
   logic       last_byte;

   modport source (output valid, func, frame_byte, last_byte, input ready);
   modport sink   (input valid, func, frame_byte, last_byte, output ready);
endinterface

interface pfcd_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        frame_kind;
   logic [15:0] payload_word;
   logic [1:0]  fan_level;
   logic [2:0]  heat_level;
   logic        summer_flag;
   logic        alert_flag;
   logic [15:0] spare_bits;

   modport source (output valid, accepted, frame_kind, payload_word, fan_level,
                   heat_level, summer_flag, alert_flag, spare_bits,
                   input ready);
   modport sink   (input valid, accepted, frame_kind, payload_word, fan_level,
                   heat_level, summer_flag, alert_flag, spare_bits,
                   output ready);
endinterface

@@ hw/rtl/pfcd_frame_tracker.sv @@
// Per-frame state of the decoder: byte index, running CRC-8, marker checks
// and payload bytes. Depends on pfcd_pkg.
`timescale 1ns / 1ps

module pfcd_frame_tracker
   import pfcd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  req_word_type      in_word,
   output frame_summary_type summary
);

   logic [2:0] byte_index_ff, byte_index_in;
   logic [7:0] crc_ff, crc_in;
   logic       kind_ff, kind_in;
   logic       markers_ff, markers_in;
   logic       crc_good_ff, crc_good_in;
   logic [7:0] word_low_ff, word_low_in;
   logic [7:0] word_high_ff, word_high_in;

   logic       kind;
   logic [2:0] len, wlo_at, crc_at;
   logic       in_layout;
   logic       marker_bad;
   logic [7:0] b;

   always_comb begin
      b         = in_word.frame_byte;
      kind      = (byte_index_ff == SYNC_AT) ? in_word.func : kind_ff;
      len       = (kind == KIND_BUTTON) ? BUTTON_LEN : STATUS_LEN;
      wlo_at    = (kind == KIND_BUTTON) ? BUTTON_WLO_AT : STATUS_WLO_AT;
      crc_at    = (kind == KIND_BUTTON) ? BUTTON_CRC_AT : STATUS_CRC_AT;
      in_layout = byte_index_ff < len;

      if (kind == KIND_STATUS) begin
         marker_bad = (byte_index_ff == SYNC_AT && b != STATUS_SYNC)
                   || (byte_index_ff == STATUS_TAG_AT && b != STATUS_TAG)
                   || (byte_index_ff == STATUS_END_AT && b != FRAME_END);
      end else begin
         marker_bad = (byte_index_ff == SYNC_AT && b != BUTTON_SYNC)
                   || (byte_index_ff == BUTTON_END_AT && b != FRAME_END);
      end

      kind_in      = kind;
      markers_in   = markers_ff && !(in_layout && marker_bad);
      word_low_in  = (in_layout && byte_index_ff == wlo_at) ? b : word_low_ff;
      word_high_in = (in_layout && byte_index_ff == wlo_at + 3'd1) ? b : word_high_ff;
      crc_in       = (in_layout && byte_index_ff < crc_at) ? crc8_update(crc_ff, b) : crc_ff;
      crc_good_in  = (in_layout && byte_index_ff == crc_at) ? (b == crc_ff) : crc_good_ff;
      byte_index_in = (byte_index_ff != INDEX_MAX) ? byte_index_ff + 3'd1 : byte_index_ff;

      summary.accepted = (byte_index_in >= len) && markers_in && crc_good_in;
      summary.kind     = kind;
      summary.word     = {word_high_in, word_low_in};
   end

   always_ff @(posedge clock) begin
      if (reset || (step && in_word.last_byte)) begin
         byte_index_ff <= '0;
         crc_ff        <= '0;
         kind_ff       <= KIND_STATUS;
         markers_ff    <= 1'b1;
         crc_good_ff   <= 1'b0;
      end else if (step) begin
         byte_index_ff <= byte_index_in;
         crc_ff        <= crc_in;
         kind_ff       <= kind_in;
         markers_ff    <= markers_in;
         crc_good_ff   <= crc_good_in;
      end
   end

   // payload bytes are only used once their positions have been written
   always_ff @(posedge clock) begin
      if (step) begin
         word_low_ff  <= word_low_in;
         word_high_ff <= word_high_in;
      end
   end

endmodule

@@ hw/rtl/pfcd_result_decode.sv @@
// Turns a finished frame summary into the result word: status fields,
// airflow and temperature levels. Depends on pfcd_pkg.
`timescale 1ns / 1ps

module pfcd_result_decode
   import pfcd_pkg::*;
(
   input  frame_summary_type summary,
   output rsp_word_type      result
);

   logic        status_ok;
   logic [15:0] w;
   logic [1:0]  airflow;
   logic [2:0]  temp;

   always_comb begin
      w         = summary.word;
      status_ok = summary.accepted && (summary.kind == KIND_STATUS);

      if (w[AIR_MIN_BIT]) begin
         airflow = AIRFLOW_MIN;
      end else if (w[AIR_NORM_BIT]) begin
         airflow = AIRFLOW_NORM;
      end else if (w[AIR_MAX_BIT]) begin
         airflow = AIRFLOW_MAX;
      end else begin
         airflow = AIRFLOW_UNKNOWN;
      end

      // bits 3..1 are high, medium, low
      case (w[3:1])
         3'b000:  temp = TEMP_NONE;
         3'b001:  temp = TEMP_LOW;
         3'b011:  temp = TEMP_LOW_MED;
         3'b010:  temp = TEMP_MED;
         3'b110:  temp = TEMP_MED_HIGH;
         3'b100:  temp = TEMP_HIGH;
         default: temp = TEMP_UNKNOWN;
      endcase

      result.accepted     = summary.accepted;
      result.frame_kind   = summary.kind;
      result.payload_word = summary.accepted ? w : 16'h0000;
      result.fan_level    = status_ok ? airflow : AIRFLOW_MIN;
      result.heat_level   = status_ok ? temp : TEMP_NONE;
      result.summer_flag  = status_ok && w[SUMMER_BIT];
      result.alert_flag   = status_ok && w[NOTIFY_BIT];
      result.spare_bits   = status_ok ? (w & ~KNOWN_MASK) : 16'h0000;
   end

endmodule

@@ hw/rtl/panel_frame_crc8_decoder.sv @@
// Top level of the panel frame CRC-8 decoder: input register, frame
// tracker, result decode and output register. Depends on pfcd_pkg, pfcd_ifs.
`timescale 1ns / 1ps

// Decodes panel frames one byte per word on req_bus and returns one result word on
// rsp_bus for every byte marked last. Status frames are FF 01 lo hi FF crc, button
// frames 00 lo hi FF crc; the CRC is CRC-8/Maxim over the bytes before the crc byte.
// A byte is taken every cycle, but a last byte only holds in the input register while
// the output register is full and not read; input keeps flowing while a result waits.
// The CRC step for a whole byte is one combinational update between the input register
// and the frame state. The output register takes a result as each last byte advances.

module panel_frame_crc8_decoder
   import pfcd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   pfcd_req_if.sink    req_bus,
   pfcd_rsp_if.source  rsp_bus
);

   logic              s1_valid_ff, s1_valid_in;
   req_word_type      s1_word_ff, s1_word_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic              req_accept;
   logic              out_free;
   logic              s1_advance;
   logic              rsp_load;
   frame_summary_type summary;
   rsp_word_type      decoded;

   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign s1_advance = s1_valid_ff && (!s1_word_ff.last_byte || out_free);
   assign rsp_load   = s1_advance && s1_word_ff.last_byte;
   assign req_bus.ready = !s1_valid_ff || s1_advance;
   assign req_accept = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
      s1_word_in  = s1_word_ff;
      if (req_accept) begin
         s1_word_in.func       = req_bus.func;
         s1_word_in.frame_byte = req_bus.frame_byte;
         s1_word_in.last_byte  = req_bus.last_byte;
      end
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
      rsp_word_in  = rsp_load ? decoded : rsp_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff  <= s1_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   pfcd_frame_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .step    (s1_advance),
      .in_word (s1_word_ff),
      .summary (summary)
   );

   pfcd_result_decode u_decode (
      .summary (summary),
      .result  (decoded)
   );

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.accepted     = rsp_word_ff.accepted;
   assign rsp_bus.frame_kind   = rsp_word_ff.frame_kind;
   assign rsp_bus.payload_word = rsp_word_ff.payload_word;
   assign rsp_bus.fan_level    = rsp_word_ff.fan_level;
   assign rsp_bus.heat_level   = rsp_word_ff.heat_level;
   assign rsp_bus.summer_flag  = rsp_word_ff.summer_flag;
   assign rsp_bus.alert_flag   = rsp_word_ff.alert_flag;
   assign rsp_bus.spare_bits   = rsp_word_ff.spare_bits;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("result valid after reset");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_bus.valid)
      else $error("last byte did not produce a result");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.accepted |->
         rsp_bus.payload_word == 16'h0000 && rsp_bus.spare_bits == 16'h0000)
      else $error("rejected frame carries payload");

   a_button_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.frame_kind == KIND_BUTTON |->
         !rsp_bus.summer_flag && !rsp_bus.alert_flag &&
         rsp_bus.heat_level == TEMP_NONE && rsp_bus.spare_bits == 16'h0000)
      else $error("button frame carries status fields");

   a_last_holds_when_full: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_word_ff.last_byte && rsp_bus.valid && !rsp_bus.ready |->
         !req_bus.ready)
      else $error("input taken while last byte blocked");

endmodule
